/* sv/telemetry_frame_packer_macros.svh */
// Assertion helpers for the frame packer; both expect clk and rst_n in scope.
`ifndef TELEMETRY_FRAME_PACKER_MACROS_SVH
`define TELEMETRY_FRAME_PACKER_MACROS_SVH

// same-cycle implication
`define TFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TFP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tfp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tfp_pkg;

  // item kinds
  localparam logic [1:0] KIND_OPEN = 2'd0;
  localparam logic [1:0] KIND_BYTE = 2'd1;
  localparam logic [1:0] KIND_HALF = 2'd2;
  localparam logic [1:0] KIND_WORD = 2'd3;

  localparam logic [7:0] SYNC_RESET  = 8'h88;
  localparam int         QUEUE_DEPTH = 4;
  localparam int         JOB_CNT_W   = 3;   // 0..4 data bytes

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  func_code;
    logic [7:0]  payload_length;
    logic [31:0] payload_word;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // one unit of work for the serialiser: up to four bytes, MSB first
  typedef struct packed {
    logic                 clr;   // restart checksum before first byte
    logic                 chk;   // append checksum after the data bytes
    logic [JOB_CNT_W-1:0] cnt;   // data bytes to send
    logic [31:0]          data;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

/* sv/tfp_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module tfp_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_valid,
  input  wire [7:0]         cfg_data,
  input  wire               in_valid,
  output logic              in_ready,
  input  tfp_pkg::in_item_t in_data,
  input  tfp_pkg::q_stat_t  q_stat,
  output logic              q_push,
  output tfp_pkg::job_t     q_wr_data
);

  logic       open_r, open_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] sync_r;
  logic [2:0] nb;
  logic       keep;
  logic       in_fire;

  assign in_ready = !q_stat.full;
  assign in_fire  = in_valid && in_ready;
  assign q_push   = in_fire && keep;

  always_comb begin
    case (in_data.kind)
      tfp_pkg::KIND_BYTE: nb = 3'd1;
      tfp_pkg::KIND_HALF: nb = 3'd2;
      default:            nb = 3'd4;
    endcase
  end

  always_comb begin
    open_nxt        = open_r;
    rem_nxt         = rem_r;
    keep            = 1'b0;
    q_wr_data.clr   = 1'b0;
    q_wr_data.chk   = 1'b0;
    q_wr_data.cnt   = nb;
    q_wr_data.data  = in_data.payload_word;
    case (in_data.kind)
      tfp_pkg::KIND_OPEN: begin
        keep           = 1'b1;
        q_wr_data.clr  = 1'b1;
        q_wr_data.cnt  = 3'd3;
        q_wr_data.data = {sync_r, in_data.func_code, in_data.payload_length, 8'h00};
        if (in_data.payload_length == 8'd0) begin
          q_wr_data.chk = 1'b1;
          open_nxt      = 1'b0;
          rem_nxt       = 8'd0;
        end else begin
          open_nxt = 1'b1;
          rem_nxt  = in_data.payload_length;
        end
      end
      default: begin
        // align the used bytes to the top
        case (in_data.kind)
          tfp_pkg::KIND_BYTE: q_wr_data.data = {in_data.payload_word[7:0], 24'h0};
          tfp_pkg::KIND_HALF: q_wr_data.data = {in_data.payload_word[15:0], 16'h0};
          default:            q_wr_data.data = in_data.payload_word;
        endcase
        keep = open_r;
        if (rem_r <= {5'd0, nb}) begin
          // this item completes the frame; excess bytes are dropped
          q_wr_data.cnt = rem_r[2:0];
          q_wr_data.chk = 1'b1;
          open_nxt      = 1'b0;
          rem_nxt       = 8'd0;
        end else begin
          rem_nxt = rem_r - {5'd0, nb};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      rem_r  <= 8'd0;
      sync_r <= tfp_pkg::SYNC_RESET;
    end else begin
      if (cfg_valid) begin
        sync_r <= cfg_data;
      end
      if (in_fire && (in_data.kind == tfp_pkg::KIND_OPEN || open_r)) begin
        open_r <= open_nxt;
        rem_r  <= rem_nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/tfp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module tfp_queue #(
  parameter int DEPTH = tfp_pkg::QUEUE_DEPTH
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  tfp_pkg::job_t    wr_data,
  input  wire              pop,
  output tfp_pkg::job_t    rd_data,
  output tfp_pkg::q_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tfp_pkg::job_t    slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign rd_data    = slot_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/tfp_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module tfp_back (
  input  wire                clk,
  input  wire                rst_n,
  input  tfp_pkg::q_stat_t   q_stat,
  input  tfp_pkg::job_t      q_rd_data,
  output logic               q_pop,
  output logic               out_valid,
  input  wire                out_ready,
  output tfp_pkg::out_item_t out_data
);

  logic                          job_vld_r;
  logic                          clr_r;
  logic                          chk_r;
  logic [tfp_pkg::JOB_CNT_W-1:0] cnt_r;
  logic [31:0]                   data_r;
  logic [7:0]                    sum_r, sum_nxt;
  logic                          out_vld_r;
  tfp_pkg::out_item_t            out_r, out_nxt;
  logic                          ld, emit, done;

  assign ld    = !out_vld_r || out_ready;
  assign emit  = ld && job_vld_r;
  assign done  = (cnt_r == '0) || (cnt_r == 3'd1 && !chk_r);
  assign q_pop = !q_stat.empty && (!job_vld_r || (emit && done));

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    if (cnt_r != '0) begin
      out_nxt.out_byte = data_r[31:24];
      out_nxt.last     = 1'b0;
      sum_nxt          = (clr_r ? 8'd0 : sum_r) + data_r[31:24];
    end else begin
      out_nxt.out_byte = sum_r;
      out_nxt.last     = 1'b1;
      sum_nxt          = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= out_nxt;
    end
    if (q_pop) begin
      clr_r  <= q_rd_data.clr;
      chk_r  <= q_rd_data.chk;
      cnt_r  <= q_rd_data.cnt;
      data_r <= q_rd_data.data;
    end else if (emit && cnt_r != '0) begin
      clr_r  <= 1'b0;
      cnt_r  <= cnt_r - 1'b1;
      data_r <= {data_r[23:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      sum_r     <= 8'd0;
    end else begin
      if (emit) begin
        sum_r <= sum_nxt;
      end
      if (q_pop) begin
        job_vld_r <= 1'b1;
      end else if (emit && done) begin
        job_vld_r <= 1'b0;
      end
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/telemetry_frame_packer.sv */
//  channel | dir | handshake           | beat
//  --------+-----+---------------------+---------------------------------------
//  in_     | in  | in_valid/in_ready   | in_item_t: kind, func, length, word
//  out_    | out | out_valid/out_ready | out_item_t: one frame byte, last flag
//  cfg_    | in  | cfg_valid/cfg_ready | sync byte (always ready)
//
//  The front takes one beat per cycle while the job queue has room.
//  The back sends one byte per cycle while out_ready holds. An item yields
//  0 bytes (dropped), 1..4 payload plus the checksum if it ends the frame,
//  3 or 4 for an open; the single output byte lane sets the sustained rate.
//  Synchronous active-low reset; sync byte returns to 0x88.
//  A stalled out_ready fills the queue, then in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

`include "telemetry_frame_packer_macros.svh"

module telemetry_frame_packer #(
  parameter int QueueDepth = tfp_pkg::QUEUE_DEPTH
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire [7:0]          cfg_data,
  input  wire                in_valid,
  output logic               in_ready,
  input  tfp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output tfp_pkg::out_item_t out_data
);

  tfp_pkg::q_stat_t q_stat;
  tfp_pkg::job_t    q_wr_data, q_rd_data;
  logic             q_push, q_pop;

  assign cfg_ready = 1'b1;

  // front: tracks frame state, turns each beat into a serialiser job or drops it
  tfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wr_data (q_wr_data)
  );

  tfp_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .stat    (q_stat)
  );

  // back: byte serialiser with running sum and registered output
  tfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_rd_data (q_rd_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `TFP_ASSERT_IMP(a_no_push_full, q_push, !q_stat.full, "job pushed into full queue")
  `TFP_ASSERT_IMP(a_no_pop_empty, q_pop, !q_stat.empty, "job popped from empty queue")
  `TFP_ASSERT_NXT(a_open_queued, in_valid && in_ready && in_data.kind == tfp_pkg::KIND_OPEN, !q_stat.empty, "open beat left no job")

endmodule

`default_nettype wire

/* tb/sv/frame_byte_checker.sv */
`timescale 1ns / 1ps

// Watches all three channels and keeps a shadow of the packer state.
// Each beat on the input side is expanded into the frame bytes it should
// yield, and each beat on the output side is compared with the oldest one.
module frame_byte_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  tfp_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  tfp_pkg::out_item_t out_data,
  output int                 mismatches,
  output int                 bytes_due,
  output int                 bytes_checked,
  output int                 frames_closed
);

  logic [7:0] sync_r;
  logic       open_r;
  logic [7:0] owed_r;
  logic [7:0] csum_r;

  tfp_pkg::out_item_t frame_bytes_q[$];

  int n_err = 0;
  int n_chk = 0;
  int n_sum = 0;

  function automatic void emit_byte(logic [7:0] b);
    tfp_pkg::out_item_t o;
    o.out_byte = b;
    o.last     = 1'b0;
    frame_bytes_q.push_back(o);
    csum_r = csum_r + b;
  endfunction

  function automatic void emit_checksum();
    tfp_pkg::out_item_t o;
    o.out_byte = csum_r;
    o.last     = 1'b1;
    frame_bytes_q.push_back(o);
    open_r = 1'b0;
    owed_r = '0;
    csum_r = '0;
  endfunction

  function automatic void pack_item(tfp_pkg::in_item_t it);
    int nb;
    if (it.kind == tfp_pkg::KIND_OPEN) begin
      // an open always restarts, abandoning any unfinished frame
      csum_r = '0;
      emit_byte(sync_r);
      emit_byte(it.func_code);
      emit_byte(it.payload_length);
      if (it.payload_length == 8'd0) begin
        emit_checksum();
      end else begin
        open_r = 1'b1;
        owed_r = it.payload_length;
      end
    end else if (open_r) begin
      nb = (it.kind == tfp_pkg::KIND_BYTE) ? 1 : (it.kind == tfp_pkg::KIND_HALF) ? 2 : 4;
      // MSB first, cut off once the declared length is reached
      for (int i = 0; i < nb && owed_r != 8'd0; i++) begin
        emit_byte(it.payload_word[8*(nb-1-i) +: 8]);
        owed_r = owed_r - 8'd1;
      end
      if (owed_r == 8'd0) begin
        emit_checksum();
      end
    end
  endfunction

  always @(posedge clk) begin
    tfp_pkg::out_item_t want;
    if (!rst_n) begin
      sync_r = tfp_pkg::SYNC_RESET;
      open_r = 1'b0;
      owed_r = '0;
      csum_r = '0;
      frame_bytes_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        sync_r = cfg_data;
      end
      if (in_valid && in_ready) begin
        pack_item(in_data);
      end
      if (out_valid && out_ready) begin
        if (frame_bytes_q.size() == 0) begin
          $error("unexpected frame byte %02h (last %0b)", out_data.out_byte, out_data.last);
          n_err++;
        end else begin
          want = frame_bytes_q.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_data.out_byte);
            n_err++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_data.last);
            n_err++;
          end
          n_chk++;
          if (want.last) begin
            n_sum++;
          end
        end
      end
    end
    mismatches    <= n_err;
    bytes_due     <= frame_bytes_q.size();
    bytes_checked <= n_chk;
    frames_closed <= n_sum;
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the frame packer. All byte checking lives in the
// checker beside the block; this module only feeds beats, writes the sync
// byte, toggles the output stall and decides pass or fail at the end.
module tb;

  localparam int ITEMS_RANDOM  = 290;
  localparam int PHASES        = 5;
  localparam int SETTLE_CYCLES = 40;      // queue of 4 jobs, 5 bytes each, plus slack
  localparam int CYCLE_LIMIT   = 400000;  // far above the slowest legal run

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [7:0]         cfg_data;
  logic               in_valid;
  logic               in_ready;
  tfp_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  tfp_pkg::out_item_t out_data;

  int mismatches;
  int bytes_due;
  int bytes_checked;
  int frames_closed;

  int cycle_cnt    = 0;
  int in_idle_pct  = 32;
  int out_idle_pct = 32;
  int items_sent   = 0;   // beats the block acts on
  int strays_sent  = 0;   // payload beats with no frame open, dropped by design
  int sync_writes  = 0;

  telemetry_frame_packer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  frame_byte_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .mismatches    (mismatches),
    .bytes_due     (bytes_due),
    .bytes_checked (bytes_checked),
    .frames_closed (frames_closed)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver stall: one fresh draw per cycle, so gaps land on every byte
  // position of a frame, checksum included.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Watchdog; a hang or a lost byte ends up here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic tfp_pkg::in_item_t mk(logic [1:0] k, logic [7:0] f, logic [7:0] l,
                                           logic [31:0] w);
    tfp_pkg::in_item_t it;
    it.kind           = k;
    it.func_code      = f;
    it.payload_length = l;
    it.payload_word   = w;
    return it;
  endfunction

  // One beat on the input channel. Valid stays up between back-to-back beats
  // and only drops for idle cycles.
  task automatic push_item(tfp_pkg::in_item_t it, bit stray);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (stray) begin
      strays_sent++;
    end else begin
      items_sent++;
    end
  endtask

  // Hold off the sender until every predicted byte is out, then give the
  // block time to swallow any dropped beats still in flight.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_sync(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sync_writes++;
  endtask

  // One well-formed frame with random content. Lengths are mostly short so
  // frames close often; a few are long, a few are cut short and left for
  // the next open to abandon. The last payload beat may overrun the length.
  task automatic send_frame();
    tfp_pkg::in_item_t it;
    logic [1:0] k;
    int r;
    int len;
    int goal;
    int done;
    r = $urandom_range(99);
    if (r < 8) begin
      len = 0;
    end else if (r < 12) begin
      len = $urandom_range(255, 40);
    end else begin
      len = $urandom_range(12, 1);
    end
    push_item(mk(tfp_pkg::KIND_OPEN, 8'($urandom), 8'(len), $urandom), 1'b0);
    goal = len;
    if (len > 0 && $urandom_range(99) < 12) begin
      goal = $urandom_range(len - 1, 0);
    end
    done = 0;
    while (done < goal) begin
      k  = 2'($urandom_range(3, 1));
      it = mk(k, 8'($urandom), 8'($urandom), $urandom);
      push_item(it, 1'b0);
      done += (k == tfp_pkg::KIND_BYTE) ? 1 : (k == tfp_pkg::KIND_HALF) ? 2 : 4;
    end
    // noise: a payload beat after the frame has closed
    if (done >= len && $urandom_range(99) < 10) begin
      k = 2'($urandom_range(3, 1));
      push_item(mk(k, 8'($urandom), 8'($urandom), $urandom), 1'b1);
    end
  endtask

  initial begin
    logic [7:0] sync_plan [PHASES];
    int base;

    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;

    sync_plan[0] = 8'h00;
    sync_plan[1] = 8'hFF;
    sync_plan[2] = 8'($urandom);
    sync_plan[3] = 8'hAF;
    sync_plan[4] = 8'($urandom);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, under the reset sync byte.
    // payload with nothing open is dropped
    push_item(mk(tfp_pkg::KIND_BYTE, 8'h00, 8'h00, 32'h0000_00AD), 1'b1);
    push_item(mk(tfp_pkg::KIND_WORD, 8'hFF, 8'hFF, 32'hFFFF_FFFF), 1'b1);
    // zero length: header and checksum at once
    push_item(mk(tfp_pkg::KIND_OPEN, 8'h00, 8'h00, 32'h0000_0000), 1'b0);
    push_item(mk(tfp_pkg::KIND_OPEN, 8'hFF, 8'h00, 32'hFFFF_FFFF), 1'b0);
    // longest declared length, left unfinished
    push_item(mk(tfp_pkg::KIND_OPEN, 8'hFF, 8'hFF, 32'h0000_0000), 1'b0);
    push_item(mk(tfp_pkg::KIND_WORD, 8'h00, 8'h00, 32'hFFFF_FFFF), 1'b0);
    push_item(mk(tfp_pkg::KIND_HALF, 8'hFF, 8'hFF, 32'h0000_0000), 1'b0);
    // reopen abandons it; then word + half + byte fill seven bytes exactly
    push_item(mk(tfp_pkg::KIND_OPEN, 8'hA1, 8'd7, 32'hFFFF_FFFF), 1'b0);
    push_item(mk(tfp_pkg::KIND_WORD, 8'h00, 8'h00, 32'h8000_0001), 1'b0);
    push_item(mk(tfp_pkg::KIND_HALF, 8'h00, 8'h00, 32'hFFFF_7FFE), 1'b0);
    push_item(mk(tfp_pkg::KIND_BYTE, 8'h00, 8'h00, 32'hFFFF_FF55), 1'b0);
    // dropped again once the frame has closed
    push_item(mk(tfp_pkg::KIND_BYTE, 8'h1C, 8'h03, 32'h0000_001C), 1'b1);
    // overlong payload is truncated at the declared length
    push_item(mk(tfp_pkg::KIND_OPEN, 8'h1C, 8'd3, 32'h0000_0000), 1'b0);
    push_item(mk(tfp_pkg::KIND_WORD, 8'h00, 8'h00, 32'h1234_5678), 1'b0);
    push_item(mk(tfp_pkg::KIND_OPEN, 8'h02, 8'd1, 32'h0000_0000), 1'b0);
    push_item(mk(tfp_pkg::KIND_HALF, 8'h00, 8'h00, 32'hFFFF_ABCD), 1'b0);
    push_item(mk(tfp_pkg::KIND_OPEN, 8'h03, 8'd2, 32'h0000_0000), 1'b0);
    push_item(mk(tfp_pkg::KIND_BYTE, 8'h00, 8'h00, 32'h0000_00AF), 1'b0);
    push_item(mk(tfp_pkg::KIND_WORD, 8'h00, 8'h00, 32'hDEAD_BEEF), 1'b0);
    push_item(mk(tfp_pkg::KIND_OPEN, 8'hAD, 8'd4, 32'h0000_0000), 1'b0);
    push_item(mk(tfp_pkg::KIND_HALF, 8'h00, 8'h00, 32'h0000_0102), 1'b0);
    push_item(mk(tfp_pkg::KIND_HALF, 8'h00, 8'h00, 32'h0000_FEFD), 1'b0);

    // Random part: one sync setting per phase, extremes included. Phase 2
    // runs with no idling on either side to keep the byte lane saturated.
    base = items_sent;
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_sync(sync_plan[ph]);
      in_idle_pct  = (ph == 2) ? 0 : 32;
      out_idle_pct = (ph == 2) ? 0 : 32;
      while (items_sent < base + (ph + 1) * (ITEMS_RANDOM / PHASES)) begin
        send_frame();
      end
    end
    settle();

    $display("Run covered %0d beats acted on and %0d dropped ones, %0d sync settings",
             items_sent, strays_sent, sync_writes + 1);
    $display("Compared %0d frame bytes, %0d frames closed by a checksum",
             bytes_checked, frames_closed);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
